FILE: design/tgad_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgad_pkg;

  localparam int unsigned CountW = 27;
  localparam logic [CountW-1:0] MaxPixels = 27'd67108864;

  typedef enum logic [1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_RLE_MODE        = 2'd1,
    CFG_PIXEL_COUNT     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] run_length;
    logic       image_complete;
  } out_word_t;

  // Effective (clamped) configuration seen by the decoder core.
  typedef struct packed {
    logic [1:0]        bpp_m1;
    logic              rle_mode;
  } dec_cfg_t;

endpackage

FILE: design/tga_rle_pixel_decoder_top.sv
// Top level of the TGA run-length pixel decoder: config registers, core, output buffer.
// A word that completes a pixel (or ends the data early) has its result registered in
//   the output buffer before it shows on out_valid_o.
// Throughput: one input word per cycle; the output buffer holds two results, so input
//   stalls only when both entries are full.
// Reset: asynchronous, active low; registers return to 4 bytes/pixel, raw mode,
//   one pixel, and decoding restarts. Any write to a known register also restarts it.
module tga_rle_pixel_decoder_top import tgad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [26:0] cfg_data_i,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  // decoded pixels out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  logic [2:0]        bpp_q, bpp_d;
  logic              rle_q, rle_d;
  logic [CountW-1:0] pcount_q, pcount_d;
  logic              restart;
  dec_cfg_t          cfg;
  logic              res_valid;
  out_word_t         res_word;

  // Clamp the pixel count: zero reads as one, oversize as the maximum.
  function automatic logic [CountW-1:0] eff_total(input logic [CountW-1:0] pc);
    logic [CountW-1:0] r;
    if (pc == '0) begin
      r = 27'd1;
    end else if (pc > MaxPixels) begin
      r = MaxPixels;
    end else begin
      r = pc;
    end
    return r;
  endfunction

  // Clamp bytes per pixel to 1..4 and store it minus one.
  function automatic logic [1:0] eff_bpp_m1(input logic [2:0] bpp);
    logic [1:0] r;
    if (bpp == 3'd0) begin
      r = 2'd0;
    end else if (bpp > 3'd4) begin
      r = 2'd3;
    end else begin
      r = 2'(bpp - 3'd1);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Register writes; a write to a known index restarts decoding.
  always_comb begin
    bpp_d    = bpp_q;
    rle_d    = rle_q;
    pcount_d = pcount_q;
    restart  = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BYTES_PER_PIXEL: begin
          bpp_d   = cfg_data_i[2:0];
          restart = 1'b1;
        end
        CFG_RLE_MODE: begin
          rle_d   = cfg_data_i[0];
          restart = 1'b1;
        end
        CFG_PIXEL_COUNT: begin
          pcount_d = cfg_data_i;
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= 3'd4;
      rle_q    <= 1'b0;
      pcount_q <= 27'd1;
    end else begin
      bpp_q    <= bpp_d;
      rle_q    <= rle_d;
      pcount_q <= pcount_d;
    end
  end

  assign cfg.bpp_m1   = eff_bpp_m1(bpp_q);
  assign cfg.rle_mode = rle_q;

  // Core takes a word whenever the output buffer has room.
  tgad_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .restart_i       (restart),
    .restart_total_i (eff_total(pcount_d)),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_word_i       (in_word_i),
    .res_valid_o     (res_valid),
    .res_word_o      (res_word)
  );

  tgad_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (res_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // An error result carries nothing but its status bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |->
      out_word_o.run_length == 8'd0 && !out_word_o.image_complete)
    else $error("error result with nonzero fields");

  // Every pixel result covers at least one pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.status |-> out_word_o.run_length != 8'd0)
    else $error("pixel result with zero run length");

  // Once the final pixel is produced, nothing follows until a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_word.image_complete && !restart |=> !res_valid)
    else $error("result after image completion");

endmodule

FILE: design/tgad_conv.sv
// Pixel format conversion from assembled source bytes to output channels.
module tgad_conv import tgad_pkg::*; (
  input  logic [1:0]  bpp_m1_i,
  input  logic [31:0] src_i,
  output logic [7:0]  ch0_o,
  output logic [7:0]  ch1_o,
  output logic [7:0]  ch2_o,
  output logic [7:0]  ch3_o
);

  logic [4:0] f0, f1, f2;

  assign f0 = src_i[4:0];
  assign f1 = src_i[9:5];
  assign f2 = src_i[14:10];

  always_comb begin
    unique case (bpp_m1_i)
      2'd0: begin
        ch0_o = src_i[7:0];
        ch1_o = 8'd0;
        ch2_o = 8'd0;
        ch3_o = 8'd0;
      end
      2'd1: begin
        // expand 5-bit channels by replicating the top bits
        ch0_o = {f0, f0[4:2]};
        ch1_o = {f1, f1[4:2]};
        ch2_o = {f2, f2[4:2]};
        ch3_o = {8{src_i[15]}};
      end
      2'd2: begin
        ch0_o = src_i[23:16];
        ch1_o = src_i[15:8];
        ch2_o = src_i[7:0];
        ch3_o = 8'hFF;
      end
      default: begin
        ch0_o = src_i[23:16];
        ch1_o = src_i[15:8];
        ch2_o = src_i[7:0];
        ch3_o = src_i[31:24];
      end
    endcase
  end

endmodule

FILE: design/tgad_core.sv
// Packet parser, pixel assembly and pixel accounting for the decoder.
module tgad_core import tgad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dec_cfg_t          cfg_i,
  input  logic              restart_i,
  input  logic [CountW-1:0] restart_total_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_word_t          in_word_i,
  output logic              res_valid_o,
  output out_word_t         res_word_o
);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhRepeat  = 2'd1;
  localparam logic [1:0] PhLiteral = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [7:0]        rem_q, rem_d;
  logic [1:0]        pos_q, pos_d;
  logic [CountW-1:0] left_q, left_d;
  logic              fin_q, fin_d;
  logic [7:0]        asm_q [3];

  logic              acc, active, hdr, pix_done, complete, err;
  logic [7:0]        b;
  logic [31:0]       src;
  logic [7:0]        run;
  logic [7:0]        ch0, ch1, ch2, ch3;

  assign acc    = in_valid_i && in_ready_i;
  assign active = acc && !fin_q;
  assign b      = in_word_i.data_byte;
  assign hdr    = cfg_i.rle_mode && (phase_q == PhHeader);

  // Insert the current byte at its slot; lower slots come from this pixel's earlier bytes.
  always_comb begin
    src[7:0]   = (pos_q == 2'd0) ? b : asm_q[0];
    src[15:8]  = (pos_q == 2'd1) ? b : asm_q[1];
    src[23:16] = (pos_q == 2'd2) ? b : asm_q[2];
    src[31:24] = b;
  end

  tgad_conv u_conv (
    .bpp_m1_i (cfg_i.bpp_m1),
    .src_i    (src),
    .ch0_o    (ch0),
    .ch1_o    (ch1),
    .ch2_o    (ch2),
    .ch3_o    (ch3)
  );

  assign pix_done = !hdr && (pos_q == cfg_i.bpp_m1);

  // Clip a repeat run to the pixels still owed.
  always_comb begin
    if (cfg_i.rle_mode && phase_q == PhRepeat) begin
      run = (left_q < {19'd0, rem_q}) ? left_q[7:0] : rem_q;
    end else begin
      run = 8'd1;
    end
  end

  assign complete = pix_done && (left_q == {19'd0, run});
  assign err      = in_word_i.end_of_data && !complete;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    left_d  = left_q;
    fin_d   = fin_q;
    if (active) begin
      if (hdr) begin
        rem_d   = {1'b0, b[6:0]} + 8'd1;
        phase_d = b[7] ? PhRepeat : PhLiteral;
        pos_d   = 2'd0;
      end else if (pix_done) begin
        pos_d  = 2'd0;
        left_d = left_q - {19'd0, run};
        if (cfg_i.rle_mode) begin
          if (phase_q == PhRepeat) begin
            phase_d = PhHeader;
            rem_d   = 8'd0;
          end else begin
            rem_d = rem_q - 8'd1;
            if (rem_d == 8'd0) begin
              phase_d = PhHeader;
            end
          end
        end
      end else begin
        pos_d = pos_q + 2'd1;
      end
      if (complete || in_word_i.end_of_data) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      rem_q   <= 8'd0;
      pos_q   <= 2'd0;
      left_q  <= 27'd1;
      fin_q   <= 1'b0;
    end else if (restart_i) begin
      phase_q <= PhHeader;
      rem_q   <= 8'd0;
      pos_q   <= 2'd0;
      left_q  <= restart_total_i;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active && !hdr && !pix_done) begin
      asm_q[pos_q] <= b;
    end
  end

  assign res_valid_o = active && (err || pix_done);

  always_comb begin
    res_word_o = '0;
    if (err) begin
      res_word_o.status = 1'b1;
    end else begin
      res_word_o.out_byte0      = ch0;
      res_word_o.out_byte1      = ch1;
      res_word_o.out_byte2      = ch2;
      res_word_o.out_byte3      = ch3;
      res_word_o.run_length     = run;
      res_word_o.image_complete = complete;
    end
  end

endmodule

FILE: design/tgad_skid.sv
// Two-entry output buffer: result register plus skid stage.
module tgad_skid import tgad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  out_word_t in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t main_q, skid_q;
  logic      push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_word_o  = main_q;

  always_comb begin
    if (main_valid_q) begin
      main_valid_d = pop ? (skid_valid_q || push) : 1'b1;
    end else begin
      main_valid_d = push;
    end
    if (skid_valid_q) begin
      skid_valid_d = !pop;
    end else begin
      skid_valid_d = push && main_valid_q && !pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : in_word_i;
    end
    if (push && main_valid_q && !pop) begin
      skid_q <= in_word_i;
    end
  end

endmodule
